@@ hdl/ssr_pkg.sv @@
// shared types and constants for the streaming substring replace block
package ssr_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int JOB_BYTES  = 8;
    localparam int JOB_W      = JOB_BYTES * BYTE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH,
        CFG_PATTERN_BYTES,
        CFG_REPLACEMENT_LENGTH,
        CFG_REPLACEMENT_BYTES
    } t_cfg_index;

    typedef struct packed {
        logic                  valid;
        t_cfg_index            index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // one item's worth of output: up to eight bytes, oldest in the low byte
    typedef struct packed {
        logic [JOB_W-1:0] bytes;
        logic [LEN_W-1:0] count;
        logic             last;
    } t_job;

endpackage

@@ hdl/ssr_queue.sv @@
// small first-in first-out queue between the front and back parts
module ssr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ssr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + CW'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hdl/ssr_front.sv @@
// front part: configuration registers, pending window, match and job forming
module ssr_front #(
    parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ssr_pkg::t_cfg_wr            i_cfg,
    input  logic                        i_valid,
    input  logic [ssr_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                        i_in_last,
    input  logic                        i_full,
    output logic                        o_push,
    output ssr_pkg::t_job               o_job
);
    import ssr_pkg::*;

    localparam int WIN_W = PATTERN_MAX * BYTE_W;
    localparam int CW    = $clog2(PATTERN_MAX + 1);

    logic [LEN_W-1:0]      r_plen;
    logic [CFG_DATA_W-1:0] r_pat;
    logic [LEN_W-1:0]      r_rlen;
    logic [CFG_DATA_W-1:0] r_rpat;
    logic [CW-1:0]         r_cnt;
    logic [WIN_W-1:0]      r_win;
    logic [CW-1:0]         n_cnt;
    logic [WIN_W-1:0]      n_win;

    logic                  accept;
    logic [LEN_W-1:0]      plen_c;
    logic [CW-1:0]         plen;
    logic [LEN_W-1:0]      rlen;
    logic [CW-1:0]         base;
    logic [CW-1:0]         cnt1;
    logic [WIN_W-1:0]      win_in;
    logic                  match;
    t_job                  job;

    assign accept = i_valid && !i_full;

    always_comb begin
        plen_c = (r_plen > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_plen;
        plen   = CW'(plen_c);
        rlen   = (r_rlen > LEN_W'(JOB_BYTES)) ? LEN_W'(JOB_BYTES) : r_rlen;
        // a full window keeps its oldest bytes and takes the new one in the last slot
        base   = (r_cnt >= CW'(PATTERN_MAX)) ? CW'(PATTERN_MAX - 1) : r_cnt;
        cnt1   = base + CW'(1);

        for (int j = 0; j < PATTERN_MAX; j++) begin
            win_in[j*BYTE_W +: BYTE_W] = (CW'(j) == base) ? i_in_byte
                                                          : r_win[j*BYTE_W +: BYTE_W];
        end

        match = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if ((CW'(j) < plen) && (win_in[j*BYTE_W +: BYTE_W] != r_pat[j*BYTE_W +: BYTE_W]))
            begin
                match = 1'b0;
            end
        end

        job.bytes = JOB_W'(win_in);
        job.count = '0;
        job.last  = i_in_last;
        n_win     = win_in;
        n_cnt     = cnt1;

        if (i_in_last) begin
            if ((plen != '0) && (cnt1 == plen) && match) begin
                job.bytes = r_rpat;
                job.count = rlen;
            end else begin
                job.count = LEN_W'(cnt1);
            end
            n_cnt = '0;
        end else if (plen == '0) begin
            job.count = LEN_W'(cnt1);
            n_cnt     = '0;
        end else if (cnt1 >= plen) begin
            if (match) begin
                job.bytes = r_rpat;
                job.count = rlen;
                n_win     = win_in >> {plen, 3'b000};
                n_cnt     = cnt1 - plen;
            end else begin
                job.bytes = JOB_W'(win_in[BYTE_W-1:0]);
                job.count = LEN_W'(1);
                n_win     = win_in >> BYTE_W;
                n_cnt     = cnt1 - CW'(1);
            end
        end
    end

    // an end-of-string job is pushed even when it carries no bytes
    assign o_push = accept && (i_in_last || (job.count != '0));
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= '0;
            r_pat  <= '0;
            r_rlen <= '0;
            r_rpat <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_PATTERN_LENGTH:     r_plen <= i_cfg.data[LEN_W-1:0];
                    CFG_PATTERN_BYTES:      r_pat  <= i_cfg.data;
                    CFG_REPLACEMENT_LENGTH: r_rlen <= i_cfg.data[LEN_W-1:0];
                    CFG_REPLACEMENT_BYTES:  r_rpat <= i_cfg.data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_cnt <= n_cnt;
            end
        end
        if (accept) begin
            r_win <= n_win;
        end
    end

endmodule

@@ hdl/ssr_back.sv @@
// back part: unpacks queued jobs into one result byte per cycle while the output is not stalled
module ssr_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  ssr_pkg::t_job              i_job,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [ssr_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_out_valid,
    output logic                       o_out_last
);
    import ssr_pkg::*;

    logic             r_cur_valid;
    t_job             r_cur;
    logic             r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic             r_o_bvalid;
    logic             r_o_last;

    logic             out_ready;
    logic             emit;
    logic             done_cur;
    logic             pop;

    assign out_ready = !r_o_valid || !i_stall;
    assign emit      = r_cur_valid && out_ready;
    assign done_cur  = emit && (r_cur.count <= LEN_W'(1));
    assign pop       = !i_empty && (!r_cur_valid || done_cur);
    assign o_pop     = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (pop) begin
                r_cur_valid <= 1'b1;
            end else if (done_cur) begin
                r_cur_valid <= 1'b0;
            end
            if (out_ready) begin
                r_o_valid <= emit;
            end
        end
        if (pop) begin
            r_cur <= i_job;
        end else if (emit) begin
            r_cur.bytes <= r_cur.bytes >> BYTE_W;
            r_cur.count <= r_cur.count - LEN_W'(1);
        end
        if (emit) begin
            r_o_byte   <= (r_cur.count == '0) ? '0 : r_cur.bytes[BYTE_W-1:0];
            r_o_bvalid <= (r_cur.count != '0);
            r_o_last   <= r_cur.last && (r_cur.count <= LEN_W'(1));
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_byte  = r_o_byte;
    assign o_out_valid = r_o_bvalid;
    assign o_out_last  = r_o_last;

endmodule

@@ hdl/streaming_substring_replace.sv @@
// top level of the streaming substring replace block
//
//  channel  handshake             payload
//  input    i_valid / o_stall     i_in_byte, i_in_last
//  output   o_valid / i_stall     o_out_byte, o_out_valid, o_out_last
//  config   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// the front takes one request per cycle while the job queue has room
// the back sends one result per cycle while not stalled, one request at a time
// a no-byte request reaches the back only at string end; output is registered
// synchronous reset clears counts and configuration; no clearing pass is needed
// a stalled output keeps its result and the queue absorbs QUEUE_DEPTH jobs
module streaming_substring_replace #(
    parameter int PATTERN_MAX = ssr_pkg::PATTERN_MAX_DEF,
    parameter int QUEUE_DEPTH = ssr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ssr_pkg::BYTE_W-1:0]     i_in_byte,
    input  logic                           i_in_last,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ssr_pkg::BYTE_W-1:0]     o_out_byte,
    output logic                           o_out_valid,
    output logic                           o_out_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ssr_pkg::*;

    t_cfg_wr cfg_wr;
    t_job    front_job;
    t_job    queue_job;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = t_cfg_index'(i_cfg_index);
    assign cfg_wr.data  = i_cfg_data;
    assign o_stall      = full;

    ssr_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_wr),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .i_full    (full),
        .o_push    (push),
        .o_job     (front_job)
    );

    ssr_queue #(
        .WIDTH ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (queue_job),
        .o_empty (empty)
    );

    ssr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (queue_job),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_out_last  (o_out_last)
    );

endmodule

@@ verif/streaming_substring_replace_test.sv @@
// self-checking testbench for the streaming substring replace block
module streaming_substring_replace_test;
    import ssr_pkg::*;

    localparam int RANDOM_ITEMS   = 215;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              present;
        logic              last;
    } t_out_item;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [BYTE_W-1:0]     i_in_byte   = '0;
    logic                  i_in_last   = 1'b0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_out_valid;
    logic                  o_out_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // configuration as the block should hold it
    logic [LEN_W-1:0]      pat_len_r   = '0;
    logic [CFG_DATA_W-1:0] pat_bytes_r = '0;
    logic [LEN_W-1:0]      rep_len_r   = '0;
    logic [CFG_DATA_W-1:0] rep_bytes_r = '0;

    // pending bytes of the current string, oldest first
    logic [BYTE_W-1:0] held_bytes [PATTERN_MAX_DEF];
    int                held_count = 0;

    t_out_item rewritten_q [$];

    logic [BYTE_W-1:0] alphabet [3];
    bit send_calm     = 1'b0;
    bit take_calm     = 1'b0;
    int mismatch_count = 0;
    int stall_left     = 0;
    int stall_draw;
    int quiet_cycles   = 0;

    streaming_substring_replace DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_out_last  (o_out_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int draw_wait(input bit calm);
        if (calm || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic bit window_hits(input int plen);
        int i;
        for (i = 0; i < plen; i++) begin
            if (held_bytes[i] != pat_bytes_r[8*i +: 8]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        t_out_item item;
        item.data    = b;
        item.present = 1'b1;
        item.last    = 1'b0;
        rewritten_q.push_back(item);
    endfunction

    function automatic void push_replacement(input int rlen);
        int i;
        for (i = 0; i < rlen; i++) begin
            push_byte(rep_bytes_r[8*i +: 8]);
        end
    endfunction

    function automatic void drop_held(input int k);
        int i;
        if (k >= held_count) begin
            held_count = 0;
        end else begin
            for (i = 0; i < held_count - k; i++) begin
                held_bytes[i] = held_bytes[i + k];
            end
            held_count = held_count - k;
        end
    endfunction

    // works out the rewritten output that one source byte releases
    function automatic void rewrite_byte(input logic [BYTE_W-1:0] b, input logic last);
        int        plen;
        int        rlen;
        int        start_size;
        int        i;
        t_out_item tail;
        plen       = (pat_len_r > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len_r);
        rlen       = (rep_len_r > JOB_BYTES) ? JOB_BYTES : int'(rep_len_r);
        start_size = rewritten_q.size();
        if (held_count >= PATTERN_MAX_DEF) begin
            held_count = PATTERN_MAX_DEF - 1;
        end
        held_bytes[held_count] = b;
        held_count++;
        if (!last) begin
            if (plen == 0) begin
                for (i = 0; i < held_count; i++) begin
                    push_byte(held_bytes[i]);
                end
                held_count = 0;
            end else if (held_count >= plen) begin
                if (window_hits(plen)) begin
                    push_replacement(rlen);
                    drop_held(plen);
                end else begin
                    push_byte(held_bytes[0]);
                    drop_held(1);
                end
            end
        end else begin
            // a window longer than the pattern is flushed without a compare
            if (plen > 0 && held_count == plen && window_hits(plen)) begin
                push_replacement(rlen);
            end else begin
                for (i = 0; i < held_count; i++) begin
                    push_byte(held_bytes[i]);
                end
            end
            held_count = 0;
            if (rewritten_q.size() == start_size) begin
                tail.data    = '0;
                tail.present = 1'b0;
            end else begin
                tail = rewritten_q.pop_back();
            end
            tail.last = 1'b1;
            rewritten_q.push_back(tail);
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        do @(posedge i_clk); while (o_stall);
        rewrite_byte(b, last);
    endtask

    // holds the input back until every expected result has come out
    task automatic pause_until_drained(input int extra);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (rewritten_q.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // leaves the write valid high so that back-to-back writes need no gap
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PATTERN_LENGTH:     pat_len_r   = value[LEN_W-1:0];
            CFG_PATTERN_BYTES:      pat_bytes_r = value;
            CFG_REPLACEMENT_LENGTH: rep_len_r   = value[LEN_W-1:0];
            CFG_REPLACEMENT_BYTES:  rep_bytes_r = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [LEN_W-1:0] plen, input logic [CFG_DATA_W-1:0] pat,
                              input logic [LEN_W-1:0] rlen, input logic [CFG_DATA_W-1:0] rep);
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(plen));
        write_reg(CFG_PATTERN_BYTES, pat);
        write_reg(CFG_REPLACEMENT_LENGTH, CFG_DATA_W'(rlen));
        write_reg(CFG_REPLACEMENT_BYTES, rep);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_pass_through();
        // reset configuration passes bytes straight through
        send_byte(8'h00, 1'b0);
        pause_until_drained(SETTLE_CYCLES);
        set_config(4'd0, '0, 4'd15, '1);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_match_replace();
        pause_until_drained(SETTLE_CYCLES);
        set_config(4'd3, 64'h636261, 4'd2, 64'h5958);
        send_byte("z", 1'b0);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte("c", 1'b0);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        // match completes on the last byte
        send_byte("c", 1'b1);
    endtask

    task automatic test_delete_to_marker();
        pause_until_drained(SETTLE_CYCLES);
        set_config(4'd2, 64'h6261, 4'd0, '0);
        send_byte("a", 1'b0);
        send_byte("b", 1'b1);
    endtask

    task automatic test_oversized_lengths();
        int i;
        pause_until_drained(SETTLE_CYCLES);
        set_config(4'd15, '1, 4'd15, 64'h8877_6655_4433_2211);
        for (i = 0; i < PATTERN_MAX_DEF; i++) begin
            send_byte(8'hFF, i == PATTERN_MAX_DEF - 1);
        end
    endtask

    task automatic test_pattern_shrink();
        pause_until_drained(SETTLE_CYCLES);
        set_config(4'd8, 64'h6867_6665_6463_6261, 4'd3, 64'h5A5958);
        send_byte("p", 1'b0);
        send_byte("q", 1'b0);
        send_byte("r", 1'b0);
        send_byte("s", 1'b0);
        // window now longer than the new pattern
        pause_until_drained(SETTLE_CYCLES);
        set_config(4'd2, 64'h7170, 4'd3, 64'h5A5958);
        send_byte("t", 1'b0);
        send_byte("u", 1'b1);
    endtask

    task automatic choose_config();
        logic [LEN_W-1:0]      plen;
        logic [LEN_W-1:0]      rlen;
        logic [CFG_DATA_W-1:0] pat;
        int                    i;
        for (i = 0; i < 3; i++) begin
            alphabet[i] = BYTE_W'($urandom_range(0, 255));
        end
        for (i = 0; i < JOB_BYTES; i++) begin
            pat[8*i +: 8] = alphabet[$urandom_range(0, 2)];
        end
        case ($urandom_range(0, 9))
            0:       plen = 4'd0;
            1:       plen = LEN_W'($urandom_range(9, 15));
            2:       plen = 4'd8;
            default: plen = LEN_W'($urandom_range(1, 7));
        endcase
        case ($urandom_range(0, 7))
            0:       rlen = 4'd0;
            1:       rlen = LEN_W'($urandom_range(9, 15));
            2:       rlen = 4'd8;
            default: rlen = LEN_W'($urandom_range(1, 7));
        endcase
        set_config(plen, pat, rlen, {$urandom, $urandom});
    endtask

    function automatic logic [BYTE_W-1:0] text_byte();
        if ($urandom_range(0, 5) == 0) begin
            return BYTE_W'($urandom_range(0, 255));
        end
        return alphabet[$urandom_range(0, 2)];
    endfunction

    // strings mix pattern fragments with other bytes so that matches are common
    task automatic test_random_strings();
        int sent;
        int len;
        int k;
        int j;
        int plen;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pause_until_drained(SETTLE_CYCLES);
            choose_config();
            repeat ($urandom_range(2, 6)) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
                send_calm = ($urandom_range(0, 4) == 0);
                take_calm = ($urandom_range(0, 4) == 0);
                k = 0;
                while (k < len) begin
                    plen = (pat_len_r > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len_r);
                    if (plen > 0 && $urandom_range(0, 3) == 0) begin
                        for (j = 0; j < plen && k < len; j++) begin
                            send_byte(pat_bytes_r[8*j +: 8], k == len - 1);
                            k++;
                        end
                    end else begin
                        // now and then the pattern changes under a part-filled window
                        if (k > 0 && $urandom_range(0, 39) == 0) begin
                            pause_until_drained(SETTLE_CYCLES);
                            choose_config();
                        end
                        send_byte(text_byte(), k == len - 1);
                        k++;
                    end
                end
                sent += len;
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rewritten_q.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", o_out_byte));
            end else begin
                want = rewritten_q.pop_front();
                if (o_out_byte !== want.data) begin
                    report_mismatch($sformatf("out_byte %h, want %h", o_out_byte, want.data));
                end
                if (o_out_valid !== want.present) begin
                    report_mismatch($sformatf("out_valid %b, want %b", o_out_valid,
                                              want.present));
                end
                if (o_out_last !== want.last) begin
                    report_mismatch($sformatf("out_last %b, want %b", o_out_last, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            stall_draw = draw_wait(take_calm);
            stall_left <= stall_draw;
            i_stall    <= (stall_draw != 0);
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_pass_through();
        test_match_replace();
        test_delete_to_marker();
        test_oversized_lengths();
        test_pattern_shrink();
        test_random_strings();
        pause_until_drained(TAIL_CYCLES);
        if (mismatch_count == 0 && rewritten_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
